[hw/rtl/nfid_pkg.sv]
// ----------------------------------------------------------------------------
// nfid_pkg
// shared types and constants of the next-fit id slot table
// ----------------------------------------------------------------------------
package nfid_pkg;

  // field widths
  localparam int SLOT_W     = 8;
  localparam int FIRST_W    = 8;
  localparam int LIMIT_W    = 9;
  localparam int KIND_W     = 2;

  // occupancy rows
  localparam int OCC_W      = 32;
  localparam int OCC_SEL_W  = $clog2(OCC_W);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // parameter defaults
  localparam int DEF_ID_SLOTS    = 256;
  localparam int DEF_HANDLE_BITS = 32;

  // register reset values
  localparam logic [FIRST_W-1:0] FIRST_RST = 8'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_ERASE    = 2'd2,
    KIND_LOOKUP   = 2'd3
  } req_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLOC_FIRST = 8'd0,
    REG_ALLOC_LIMIT = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } occ_ctl_t;

endpackage

[hw/rtl/nfid_occ_store.sv]
// ----------------------------------------------------------------------------
// nfid_occ_store
// occupancy memory in rows of OCC_W bits, one read or write per cycle,
// registered read data; a row never written since reset reads as all free
// ----------------------------------------------------------------------------
module nfid_occ_store
  import nfid_pkg::*;
#(
  parameter int ROWS  = 8,
  parameter int ROW_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  occ_ctl_t         ctl_i,
  input  logic [ROW_W-1:0] addr_i,
  input  logic [OCC_W-1:0] wdata_i,
  output logic [OCC_W-1:0] rdata_o
);

  logic [OCC_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld_q;
  logic [OCC_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        row_vld_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rvld_q <= row_vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[hw/rtl/next_fit_id_slot_table_core.sv]
// ----------------------------------------------------------------------------
// next_fit_id_slot_table_core
// slot table with occupancy and handle memories and a next-fit allocator
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Register, erase and lookup of an in-range
// slot pass through accept, dispatch with a memory read, check and write back,
// and the result load. Allocate passes through accept and dispatch, then scans
// occupancy rows, reading one row of 32 occupancy bits per cycle, first from
// the cursor to the window limit and then from the window start up to the
// cursor, and ends with the result load. The occupancy memory keeps one valid
// flag per row that reset clears, so there is no clearing pass after reset. A
// result waiting in the output register does not block the next request; the
// configuration port is always ready, and it must be written only while idle,
// which the block itself does not enforce.
module next_fit_id_slot_table_core
  import nfid_pkg::*;
#(
  parameter int ID_SLOTS    = DEF_ID_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: slot_id, entry_handle
  input  logic [((SLOT_W+HANDLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: ok, alloc_id, handle_out
  output logic [((1+SLOT_W+HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_W    = ((1 + SLOT_W + HANDLE_BITS + 7) / 8) * 8;
  localparam int IDX_W    = $clog2(ID_SLOTS);
  localparam int OCC_ROWS = (ID_SLOTS + OCC_W - 1) / OCC_W;
  localparam int ROW_W    = (OCC_ROWS > 1) ? $clog2(OCC_ROWS) : 1;
  localparam int SROW_W   = LIMIT_W - OCC_SEL_W;

  state_e                  state_q, state_d;
  req_kind_e               kind_q, kind_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [HANDLE_BITS-1:0]  hin_q, hin_d;
  logic [FIRST_W-1:0]      first_q;
  logic [LIMIT_W-1:0]      limit_q;
  logic [FIRST_W-1:0]      cursor_q, cursor_d;
  logic [LIMIT_W-1:0]      start_q, start_d;
  logic [LIMIT_W-1:0]      lo_q, lo_d;
  logic [LIMIT_W-1:0]      hi_q, hi_d;
  logic                    phase_q, phase_d;
  logic [SROW_W-1:0]       row_q, row_d;
  logic                    res_ok_q, res_ok_d;
  logic [SLOT_W-1:0]       res_id_q, res_id_d;
  logic [HANDLE_BITS-1:0]  res_h_q, res_h_d;
  logic                    out_vld_q, out_vld_d;
  logic                    out_ok_q;
  logic [SLOT_W-1:0]       out_id_q;
  logic [HANDLE_BITS-1:0]  out_h_q;
  logic                    out_load;

  logic [LIMIT_W-1:0]      lim_eff;
  logic                    win_ok;
  logic [LIMIT_W-1:0]      c_norm;
  logic                    slot_ok;
  logic [LIMIT_W-1:0]      slot_ext;
  logic [LIMIT_W-1:0]      occ_pos;

  occ_ctl_t                occ_ctl;
  logic [OCC_W-1:0]        occ_rdata;
  logic [OCC_W-1:0]        occ_wdata;
  logic                    occ_bit;

  logic [HANDLE_BITS-1:0]  hnd_mem [ID_SLOTS];
  logic [HANDLE_BITS-1:0]  hnd_rdata_q;
  logic                    hnd_re, hnd_we;

  logic [OCC_W-1:0]        free_bits;
  logic                    free_any;
  logic [OCC_SEL_W-1:0]    free_pos;
  logic [LIMIT_W-1:0]      found_id;
  logic [LIMIT_W-1:0]      found_nxt;
  logic [SROW_W-1:0]       last_row;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FIRST_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ALLOC_FIRST: first_q <= cfg_data_i[FIRST_W-1:0];
        REG_ALLOC_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // window and cursor
  assign lim_eff  = (32'(limit_q) > ID_SLOTS) ? LIMIT_W'(ID_SLOTS) : limit_q;
  assign win_ok   = {1'b0, first_q} < lim_eff;
  assign c_norm   = (cursor_q < first_q || {1'b0, cursor_q} >= lim_eff) ?
                    {1'b0, first_q} : {1'b0, cursor_q};
  assign slot_ext = {1'b0, slot_q};
  assign slot_ok  = 32'(slot_q) < ID_SLOTS;
  assign occ_bit  = occ_rdata[slot_q[OCC_SEL_W-1:0]];

  // free slots of the current row within [lo, hi)
  always_comb begin
    logic [LIMIT_W-1:0] idx;
    free_bits = '0;
    for (int j = 0; j < OCC_W; j++) begin
      idx          = {row_q, OCC_SEL_W'(j)};
      free_bits[j] = !occ_rdata[j] && idx >= lo_q && idx < hi_q;
    end
  end

  always_comb begin
    free_pos = '0;
    for (int j = OCC_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        free_pos = OCC_SEL_W'(j);
      end
    end
  end

  assign free_any  = |free_bits;
  assign found_id  = {row_q, free_pos};
  assign found_nxt = found_id + LIMIT_W'(1);
  assign last_row  = SROW_W'((hi_q - LIMIT_W'(1)) >> OCC_SEL_W);

  // control
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    slot_d    = slot_q;
    hin_d     = hin_q;
    cursor_d  = cursor_q;
    start_d   = start_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    phase_d   = phase_q;
    row_d     = row_q;
    res_ok_d  = res_ok_q;
    res_id_d  = res_id_q;
    res_h_d   = res_h_q;
    occ_ctl   = '0;
    occ_pos   = slot_ext;
    occ_wdata = occ_rdata;
    hnd_re    = 1'b0;
    hnd_we    = 1'b0;
    out_load  = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          kind_d  = req_kind_e'(s_axis_tuser);
          slot_d  = s_axis_tdata[SLOT_W-1:0];
          hin_d   = s_axis_tdata[SLOT_W +: HANDLE_BITS];
          state_d = ST_START;
        end
      end
      ST_START: begin
        res_ok_d = 1'b0;
        res_id_d = '0;
        res_h_d  = '0;
        if (kind_q == KIND_ALLOC) begin
          if (!win_ok) begin
            state_d = ST_DONE;
          end else begin
            start_d    = c_norm;
            lo_d       = c_norm;
            hi_d       = lim_eff;
            phase_d    = 1'b0;
            row_d      = SROW_W'(c_norm >> OCC_SEL_W);
            occ_pos    = c_norm;
            occ_ctl.rd = 1'b1;
            state_d    = ST_SCAN;
          end
        end else if (!slot_ok) begin
          state_d = ST_DONE;
        end else begin
          occ_ctl.rd = 1'b1;
          hnd_re     = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (kind_q)
          KIND_REGISTER: begin
            if (!occ_bit) begin
              occ_wdata[slot_q[OCC_SEL_W-1:0]] = 1'b1;
              occ_ctl.wr = 1'b1;
              hnd_we     = 1'b1;
              res_ok_d   = 1'b1;
            end
          end
          KIND_ERASE: begin
            if (occ_bit) begin
              occ_wdata[slot_q[OCC_SEL_W-1:0]] = 1'b0;
              occ_ctl.wr = 1'b1;
              res_ok_d   = 1'b1;
            end
          end
          KIND_LOOKUP: begin
            res_ok_d = occ_bit;
            res_h_d  = occ_bit ? hnd_rdata_q : '0;
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (free_any) begin
          res_ok_d = 1'b1;
          res_id_d = found_id[SLOT_W-1:0];
          cursor_d = (found_nxt >= lim_eff) ? first_q : found_nxt[FIRST_W-1:0];
          state_d  = ST_DONE;
        end else if (row_q == last_row) begin
          if (!phase_q && start_q > {1'b0, first_q}) begin
            phase_d    = 1'b1;
            lo_d       = {1'b0, first_q};
            hi_d       = start_q;
            row_d      = SROW_W'({1'b0, first_q} >> OCC_SEL_W);
            occ_pos    = {1'b0, first_q};
            occ_ctl.rd = 1'b1;
          end else begin
            cursor_d = start_q[FIRST_W-1:0];
            state_d  = ST_DONE;
          end
        end else begin
          row_d      = row_q + SROW_W'(1);
          occ_pos    = {row_q + SROW_W'(1), OCC_SEL_W'(0)};
          occ_ctl.rd = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load | (out_vld_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cursor_q  <= FIRST_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    hin_q    <= hin_d;
    start_q  <= start_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    phase_q  <= phase_d;
    row_q    <= row_d;
    res_ok_q <= res_ok_d;
    res_id_q <= res_id_d;
    res_h_q  <= res_h_d;
    if (out_load) begin
      out_ok_q <= res_ok_q;
      out_id_q <= res_id_q;
      out_h_q  <= res_h_q;
    end
  end

  // handle memory
  always_ff @(posedge clk_i) begin
    if (hnd_we) begin
      hnd_mem[IDX_W'(slot_q)] <= hin_q;
    end
    if (hnd_re) begin
      hnd_rdata_q <= hnd_mem[IDX_W'(slot_q)];
    end
  end

  // occupancy memory
  nfid_occ_store #(
    .ROWS  (OCC_ROWS),
    .ROW_W (ROW_W)
  ) u_occ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (occ_ctl),
    .addr_i  (ROW_W'(occ_pos >> OCC_SEL_W)),
    .wdata_i (occ_wdata),
    .rdata_o (occ_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_h_q, out_id_q, out_ok_q});

  // assertions
  a_alloc_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && kind_q == KIND_ALLOC && res_ok_q) |->
      ({1'b0, res_id_q} >= {1'b0, first_q} && {1'b0, res_id_q} < lim_eff))
    else $error("allocated slot outside the search window");

  a_cursor_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && kind_q == KIND_ALLOC && win_ok) |->
      (cursor_q >= first_q && {1'b0, cursor_q} < lim_eff))
    else $error("search cursor left the window");

  a_id_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && kind_q != KIND_ALLOC) |-> res_id_q == '0)
    else $error("nonzero alloc id on a table request");

  a_handle_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ok_q) |-> out_h_q == '0)
    else $error("handle returned without success");

  a_occ_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(occ_ctl.rd && occ_ctl.wr))
    else $error("occupancy read and write in one cycle");

endmodule

[test/next_fit_id_slot_table_core_test.sv]
// ----------------------------------------------------------------------------
// next_fit_id_slot_table_core_test
// self-checking bench for the next-fit id slot table core
// ----------------------------------------------------------------------------
// Requests come from a queue and are driven on the request stream with random
// gaps. Each accepted transaction is run through a behavioral copy of the slot
// table, and every reply is compared with the oldest expected reply. The
// allocation window is moved between phases, including empty, single-slot
// and full-table windows.
// ----------------------------------------------------------------------------
module next_fit_id_slot_table_core_test;
  import nfid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_SLOTS = DEF_ID_SLOTS;
  localparam int HB       = DEF_HANDLE_BITS;
  localparam int IN_W     = ((SLOT_W + HB + 7) / 8) * 8;
  localparam int OUT_W    = ((1 + SLOT_W + HB + 7) / 8) * 8;
  localparam int PLAN     = 0;
  localparam int CHK      = 1;

  typedef struct packed {
    req_kind_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [HB-1:0]     handle;
  } slot_req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] alloc_id;
    logic [HB-1:0]     handle;
  } slot_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  slot_req_t request_q[$];
  slot_rsp_t reply_q[$];

  // two copies of the table: one for planning stimulus, one for checking
  bit            occ_map    [2][ID_SLOTS];
  logic [HB-1:0] handle_map [2][ID_SLOTS];
  int            scan_cursor[2] = '{0, 0};
  int            win_first  [2] = '{int'(FIRST_RST), int'(FIRST_RST)};
  int            win_limit  [2] = '{int'(LIMIT_RST), int'(LIMIT_RST)};

  int  mismatch_cnt = 0;
  bit  req_taken = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  bit  rx_hold = 1'b0;
  bit  pressure_go = 1'b0;
  bit  calm = 1'b0;

  next_fit_id_slot_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic slot_rsp_t serve_request(int m, slot_req_t r);
    slot_rsp_t p;
    int        lim;
    int        c;
    int        i;
    bit        busy;
    p = '0;
    case (r.kind)
      KIND_ALLOC: begin
        lim = (win_limit[m] > ID_SLOTS) ? ID_SLOTS : win_limit[m];
        if (win_first[m] < lim) begin
          c = scan_cursor[m];
          if (c < win_first[m] || c >= lim) c = win_first[m];
          for (i = 0; i < lim - win_first[m]; i++) begin
            busy = occ_map[m][c];
            if (!busy) begin
              p.ok = 1'b1;
              p.alloc_id = c[SLOT_W-1:0];
            end
            c++;
            if (c >= lim) c = win_first[m];
            if (!busy) break;
          end
          scan_cursor[m] = c;
        end
      end
      KIND_REGISTER: begin
        if (!occ_map[m][r.slot]) begin
          occ_map[m][r.slot] = 1'b1;
          handle_map[m][r.slot] = r.handle;
          p.ok = 1'b1;
        end
      end
      KIND_ERASE: begin
        if (occ_map[m][r.slot]) begin
          occ_map[m][r.slot] = 1'b0;
          p.ok = 1'b1;
        end
      end
      default: begin
        if (occ_map[m][r.slot]) begin
          p.ok = 1'b1;
          p.handle = handle_map[m][r.slot];
        end
      end
    endcase
    return p;
  endfunction

  function automatic slot_rsp_t queue_req(req_kind_e kind, int slot, logic [HB-1:0] handle);
    slot_req_t r;
    r.kind = kind;
    r.slot = slot[SLOT_W-1:0];
    r.handle = handle;
    request_q.push_back(r);
    return serve_request(PLAN, r);
  endfunction

  function automatic int pick_in_window();
    int lim;
    lim = (win_limit[PLAN] > ID_SLOTS) ? ID_SLOTS : win_limit[PLAN];
    if (win_first[PLAN] < lim) return $urandom_range(win_first[PLAN], lim - 1);
    return $urandom_range(0, ID_SLOTS - 1);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (tx_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap <= $urandom_range(0, 3);
      end else if (request_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= request_q[0].kind;
        s_axis_tdata <= IN_W'({request_q[0].handle, request_q[0].slot});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // reply receiver
  always @(negedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // long receiver hold so the core backs up into the request stream
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // monitor: predict on request transaction, check on reply transaction
  always @(posedge clk_i) begin
    slot_req_t r;
    slot_rsp_t e;
    slot_rsp_t got;
    if (s_axis_tvalid && s_axis_tready) begin
      r.kind = req_kind_e'(s_axis_tuser);
      r.slot = s_axis_tdata[SLOT_W-1:0];
      r.handle = s_axis_tdata[SLOT_W+HB-1:SLOT_W];
      reply_q.push_back(serve_request(CHK, r));
      void'(request_q.pop_front());
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.ok = m_axis_tdata[0];
      got.alloc_id = m_axis_tdata[SLOT_W:1];
      got.handle = m_axis_tdata[SLOT_W+HB:SLOT_W+1];
      if (reply_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected reply %h", m_axis_tdata);
      end else begin
        e = reply_q.pop_front();
        if (got.ok !== e.ok || got.alloc_id !== e.alloc_id || got.handle !== e.handle) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("reply mismatch: expected ok %b id %0d handle %h, got ok %b id %0d handle %h",
                     e.ok, e.alloc_id, e.handle, got.ok, got.alloc_id, got.handle);
        end
      end
    end
  end

  task automatic wait_idle();
    while (request_q.size() != 0 || reply_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_ALLOC_FIRST) win_first[CHK] = value & 8'hff;
    else win_limit[CHK] = value & 9'h1ff;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(int first, int limit);
    wait_idle();
    write_reg(REG_ALLOC_FIRST, first);
    write_reg(REG_ALLOC_LIMIT, limit);
    win_first[PLAN] = first;
    win_limit[PLAN] = limit;
    @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    int        cnt;
    int        roll;
    slot_rsp_t p;
    cnt = 0;
    while (cnt < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        p = queue_req(KIND_ALLOC, $urandom_range(0, 255), $urandom);
        cnt++;
        if (p.ok && $urandom_range(0, 3) != 0) begin
          void'(queue_req(KIND_REGISTER, p.alloc_id, $urandom));
          cnt++;
          if ($urandom_range(0, 1) == 1) begin
            void'(queue_req(KIND_LOOKUP, p.alloc_id, $urandom));
            cnt++;
          end
        end
      end else if (roll < 65) begin
        void'(queue_req(KIND_ERASE, pick_in_window(), $urandom));
        cnt++;
      end else if (roll < 80) begin
        void'(queue_req(KIND_LOOKUP, pick_in_window(), $urandom));
        cnt++;
      end else if (roll < 88) begin
        void'(queue_req(KIND_REGISTER, pick_in_window(), $urandom));
        cnt++;
      end else begin
        void'(queue_req(req_kind_e'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom));
        cnt++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed part at the reset window
    void'(queue_req(KIND_LOOKUP, 0, 32'h0));
    void'(queue_req(KIND_LOOKUP, 255, 32'hffffffff));
    void'(queue_req(KIND_REGISTER, 0, 32'hffffffff));
    void'(queue_req(KIND_REGISTER, 255, 32'h0));
    void'(queue_req(KIND_REGISTER, 0, 32'h12345678));
    void'(queue_req(KIND_LOOKUP, 0, 32'h0));
    void'(queue_req(KIND_LOOKUP, 255, 32'h0));
    void'(queue_req(KIND_ERASE, 0, 32'h0));
    void'(queue_req(KIND_ERASE, 0, 32'h0));
    void'(queue_req(KIND_ALLOC, 0, 32'h0));
    void'(queue_req(KIND_ALLOC, 255, 32'hffffffff));
    void'(queue_req(KIND_REGISTER, 1, 32'ha5a5a5a5));
    void'(queue_req(KIND_ERASE, 255, 32'h0));

    // cursor below the window, then fill the window
    set_window(250, 256);
    void'(queue_req(KIND_ALLOC, 0, 32'h0));
    for (i = 250; i < 256; i++) void'(queue_req(KIND_REGISTER, i, $urandom));
    void'(queue_req(KIND_ALLOC, 0, 32'h0));
    void'(queue_req(KIND_ERASE, 253, 32'h0));
    void'(queue_req(KIND_ALLOC, 0, 32'h0));

    // empty windows
    set_window(40, 40);
    void'(queue_req(KIND_ALLOC, 0, 32'h0));
    set_window(200, 100);
    void'(queue_req(KIND_ALLOC, 0, 32'h0));

    // single slot window
    set_window(0, 1);
    void'(queue_req(KIND_ALLOC, 0, 32'h0));
    void'(queue_req(KIND_REGISTER, 0, $urandom));
    void'(queue_req(KIND_ALLOC, 0, 32'h0));

    set_window(0, 256);
    pressure_go = 1'b1;
    add_random(300);
    set_window(16, 48);
    add_random(180);
    set_window(100, 108);
    add_random(140);
    set_window(0, 1);
    add_random(60);
    set_window(255, 256);
    add_random(60);
    set_window(128, 256);
    add_random(180);
    set_window(3, 5);
    add_random(60);
    set_window(0, 256);
    calm = 1'b1;
    add_random(200);

    wait_idle();
    repeat (32) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/nfid_pkg.sv
hw/rtl/nfid_occ_store.sv
hw/rtl/next_fit_id_slot_table_core.sv
test/next_fit_id_slot_table_core_test.sv
